### src/stpw_pkg.sv
package stpw_pkg;

   localparam int BandCount = 9;

   localparam logic [15:0] LOW_EDGE  = 16'd9500;
   localparam logic [15:0] HIGH_EDGE = 16'd21500;

   // Exclusive upper bound of each band; the last one covers the high edge
   localparam logic [15:0] BAND_TOP [BandCount] = '{
      16'd9860, 16'd10730, 16'd11540, 16'd12910, 16'd14470,
      16'd16150, 16'd17910, 16'd19720, 16'd21501
   };
   localparam logic [2:0] BAND_CODE [BandCount] = '{
      3'd5, 3'd6, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6
   };
   // 1 selects prescaler 16, 0 selects prescaler 32
   localparam logic BAND_PRE16 [BandCount] = '{
      1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
   };
   localparam logic BAND_SHIFT [BandCount] = '{
      1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0
   };

   // x / 10 == (x * 52429) >> 19 for every 16-bit x
   localparam logic [15:0] DIV10_MUL   = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   localparam logic [4:0] FILTER_BIAS = 5'd10;
   localparam logic [3:0] FILTER_OFFS = 4'd3;

   localparam logic [7:0] WORD_BYTE2 = 8'hC0;
   localparam logic [7:0] START_BYTE = 8'hC4;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef struct packed {
      logic [15:0] freq_100khz;
      logic [15:0] filter_width;
   } req_type;

   typedef struct packed {
      logic       status;
      logic [7:0] word_byte0;
      logic [7:0] word_byte1;
      logic [7:0] word_byte2;
      logic [7:0] word_byte3;
      logic [7:0] start_byte;
      logic [7:0] final_byte2;
      logic [7:0] final_byte3;
   } rsp_type;

   typedef struct packed {
      logic       in_range;
      logic [2:0] code;
      logic       pre16;
      logic       shift;
   } band_type;

endpackage

### src/satellite_tuner_pll_word_core.sv
// Path: a request is held in the input register, passes the combinational
// calc and is registered again in the response register on rsp_payload.
// Throughput: one request per cycle unless rsp_stall holds the pipeline;
// the two registers form a stall-aware pipeline, so a new request is taken
// while a finished response waits, as long as the input register is empty.
// Reset: synchronous, active high; clears both valid flags, data is not reset.
module satellite_tuner_pll_word_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  stpw_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output stpw_pkg::rsp_type rsp_payload
);

   logic              s1_valid_ff, s1_valid_in;
   stpw_pkg::req_type s1_data_ff, s1_data_in;
   logic              s2_valid_ff, s2_valid_in;
   stpw_pkg::rsp_type s2_data_ff, s2_data_in;
   stpw_pkg::rsp_type calc_rsp;
   logic              s2_load;
   logic              s1_load;

   stpw_calc u_calc (
      .req (s1_data_ff),
      .rsp (calc_rsp)
   );

   always_comb begin
      s2_load   = !s2_valid_ff || !rsp_stall;
      s1_load   = !s1_valid_ff || s2_load;
      req_stall = !s1_load;

      s1_valid_in = s1_load ? req_valid : s1_valid_ff;
      s1_data_in  = (s1_load && req_valid) ? req_payload : s1_data_ff;
      s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;
      s2_data_in  = (s2_load && s1_valid_ff) ? calc_rsp : s2_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign rsp_valid   = s2_valid_ff;
   assign rsp_payload = s2_data_ff;

   // hold the input stage while the response stage cannot take it
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_load |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("input stage lost or changed a held request");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_stall)
      else $error("request stalled while pipeline has room");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == stpw_pkg::STATUS_RANGE |->
         rsp_payload.word_byte0 == 8'd0 && rsp_payload.word_byte3 == 8'd0 &&
         rsp_payload.final_byte2 == 8'd0 && rsp_payload.final_byte3 == 8'd0)
      else $error("out of range response carries nonzero bytes");

   a_ok_fixed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == stpw_pkg::STATUS_OK |->
         rsp_payload.word_byte2 == stpw_pkg::WORD_BYTE2 &&
         rsp_payload.start_byte == stpw_pkg::START_BYTE &&
         rsp_payload.word_byte0[7:5] == 3'b011)
      else $error("in range response has wrong fixed bytes");

endmodule

### src/stpw_band.sv
module stpw_band (
   input  logic [15:0]        freq_100khz,
   output stpw_pkg::band_type band
);

   always_comb begin
      band.in_range = (freq_100khz >= stpw_pkg::LOW_EDGE) &&
                      (freq_100khz <= stpw_pkg::HIGH_EDGE);
      band.code  = stpw_pkg::BAND_CODE[stpw_pkg::BandCount - 1];
      band.pre16 = stpw_pkg::BAND_PRE16[stpw_pkg::BandCount - 1];
      band.shift = stpw_pkg::BAND_SHIFT[stpw_pkg::BandCount - 1];
      // walk down so the lowest matching band wins
      for (int k = stpw_pkg::BandCount - 1; k >= 0; k--) begin
         if (freq_100khz < stpw_pkg::BAND_TOP[k]) begin
            band.code  = stpw_pkg::BAND_CODE[k];
            band.pre16 = stpw_pkg::BAND_PRE16[k];
            band.shift = stpw_pkg::BAND_SHIFT[k];
         end
      end
   end

endmodule

### src/stpw_calc.sv
module stpw_calc (
   input  stpw_pkg::req_type req,
   output stpw_pkg::rsp_type rsp
);

   stpw_pkg::band_type band;
   logic [31:0] mhz_prod;
   logic [31:0] wq_prod;
   logic [11:0] mhz;
   logic [11:0] divider;
   logic [4:0]  swallow;
   logic [4:0]  wdiff;
   logic [3:0]  fcode;
   logic [7:0]  byte3;

   stpw_band u_band (
      .freq_100khz (req.freq_100khz),
      .band        (band)
   );

   always_comb begin
      mhz_prod = {16'd0, req.freq_100khz} * {16'd0, stpw_pkg::DIV10_MUL};
      wq_prod  = {16'd0, req.filter_width} * {16'd0, stpw_pkg::DIV10_MUL};
      mhz      = mhz_prod[stpw_pkg::DIV10_SHIFT +: 12];

      if (band.pre16) begin
         divider = {4'd0, mhz[11:4]};
         swallow = {1'b0, mhz[3:0]};
      end else begin
         divider = {5'd0, mhz[11:5]};
         swallow = mhz[4:0];
      end

      // only bits 4..1 of the wrapped difference survive the halving
      wdiff = wq_prod[stpw_pkg::DIV10_SHIFT +: 5] - stpw_pkg::FILTER_BIAS;
      fcode = wdiff[4:1] + stpw_pkg::FILTER_OFFS;

      byte3 = {band.code, band.pre16, 2'b00, band.shift, 1'b0};

      if (band.in_range) begin
         rsp.status      = stpw_pkg::STATUS_OK;
         rsp.word_byte0  = {3'b011, divider[7:3]};
         rsp.word_byte1  = {divider[2:0], swallow};
         rsp.word_byte2  = stpw_pkg::WORD_BYTE2;
         rsp.word_byte3  = byte3;
         rsp.start_byte  = stpw_pkg::START_BYTE;
         rsp.final_byte2 = stpw_pkg::START_BYTE | {3'b000, fcode[0], fcode[1], 3'b000};
         rsp.final_byte3 = byte3 | {4'b0000, fcode[2], fcode[3], 2'b00};
      end else begin
         rsp             = '0;
         rsp.status      = stpw_pkg::STATUS_RANGE;
      end
   end

endmodule

### test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   class pll_word_scoreboard;
      stpw_pkg::rsp_type expected_words[$];
      int unsigned       mismatches;

      function new();
         mismatches = 0;
      endfunction

      static function stpw_pkg::rsp_type predict_pll_word(stpw_pkg::req_type r);
         stpw_pkg::rsp_type w;
         logic [2:0]  code;
         logic        pre16;
         logic        shift;
         logic [31:0] mhz;
         logic [31:0] pre;
         logic [31:0] dv;
         logic [31:0] sw;
         logic [31:0] fc;
         logic [7:0]  b3;
         w = '0;
         if (r.freq_100khz < 16'd9500 || r.freq_100khz > 16'd21500) begin
            w.status = stpw_pkg::STATUS_RANGE;
            return w;
         end
         pre16 = 1'b0;
         shift = 1'b0;
         if (r.freq_100khz < 16'd9860) begin
            code = 3'd5;
            pre16 = 1'b1;
            shift = 1'b1;
         end else if (r.freq_100khz < 16'd10730) begin
            code = 3'd6;
            pre16 = 1'b1;
            shift = 1'b1;
         end else if (r.freq_100khz < 16'd11540) begin
            code = 3'd7;
            shift = 1'b1;
         end else if (r.freq_100khz < 16'd12910) begin
            code = 3'd1;
         end else if (r.freq_100khz < 16'd14470) begin
            code = 3'd2;
         end else if (r.freq_100khz < 16'd16150) begin
            code = 3'd3;
         end else if (r.freq_100khz < 16'd17910) begin
            code = 3'd4;
         end else if (r.freq_100khz < 16'd19720) begin
            code = 3'd5;
         end else begin
            code = 3'd6;
         end
         mhz = {16'd0, r.freq_100khz} / 32'd10;
         pre = pre16 ? 32'd16 : 32'd32;
         sw = mhz % pre;
         dv = mhz / pre;
         b3 = {code, pre16, 2'b00, shift, 1'b0};
         // filter code wraps below zero for narrow widths; keep 32-bit math
         fc = {16'd0, r.filter_width} / 32'd10;
         fc = fc - 32'd10;
         fc = fc / 32'd2 + 32'd3;
         w.status      = stpw_pkg::STATUS_OK;
         w.word_byte0  = (8'h60 | {3'b000, dv[7:3]}) & 8'h7f;
         w.word_byte1  = {dv[2:0], sw[4:0]};
         w.word_byte2  = 8'hC0;
         w.word_byte3  = b3;
         w.start_byte  = 8'hC4;
         w.final_byte2 = 8'hC4 | {3'b000, fc[0], fc[1], 3'b000};
         w.final_byte3 = b3 | {4'b0000, fc[2], fc[3], 2'b00};
         return w;
      endfunction

      function void note_request(stpw_pkg::req_type r);
         expected_words.push_back(predict_pll_word(r));
      endfunction

      function void compare_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
         if (act_val !== exp_val) begin
            $error("%s expected %0h actual %0h", name, exp_val, act_val);
            mismatches++;
         end
      endfunction

      function void check_response(stpw_pkg::rsp_type got);
         stpw_pkg::rsp_type want;
         if (expected_words.size() == 0) begin
            $error("response with no request outstanding: %0h", got);
            mismatches++;
            return;
         end
         want = expected_words.pop_front();
         compare_field("status", {7'd0, want.status}, {7'd0, got.status});
         compare_field("word_byte0", want.word_byte0, got.word_byte0);
         compare_field("word_byte1", want.word_byte1, got.word_byte1);
         compare_field("word_byte2", want.word_byte2, got.word_byte2);
         compare_field("word_byte3", want.word_byte3, got.word_byte3);
         compare_field("start_byte", want.start_byte, got.start_byte);
         compare_field("final_byte2", want.final_byte2, got.final_byte2);
         compare_field("final_byte3", want.final_byte3, got.final_byte3);
      endfunction
   endclass

   localparam int unsigned RandomPerPhase = 410;
   localparam int unsigned DrainCycles    = 8;

   // band boundaries plus the two range edges
   localparam logic [15:0] FREQ_EDGES [11] = '{
      16'd9500, 16'd9860, 16'd10730, 16'd11540, 16'd12910, 16'd14470,
      16'd16150, 16'd17910, 16'd19720, 16'd21500, 16'd21501
   };
   localparam logic [15:0] WIDTH_PICKS [12] = '{
      16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd109,
      16'd110, 16'd119, 16'd65535, 16'd65530, 16'd255, 16'd1000
   };
   localparam logic [15:0] DIRECTED_FREQS [22] = '{
      16'd0, 16'd65535, 16'd9499, 16'd9500, 16'd9859, 16'd9860, 16'd10729,
      16'd10730, 16'd11539, 16'd11540, 16'd12909, 16'd12910, 16'd14469,
      16'd14470, 16'd16149, 16'd16150, 16'd17909, 16'd17910, 16'd19719,
      16'd19720, 16'd21500, 16'd21501
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   stpw_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   stpw_pkg::rsp_type rsp_payload;

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   pll_word_scoreboard board = new();

   satellite_tuner_pll_word_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_response(rsp_payload);
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_request(input stpw_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   function automatic stpw_pkg::req_type random_request();
      stpw_pkg::req_type r;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 75) begin
         r.freq_100khz = 16'($urandom_range(9500, 21500));
      end else if (pick < 87) begin
         // land within a few steps of a band or range edge
         r.freq_100khz = FREQ_EDGES[$urandom_range(10)] + 16'($urandom_range(6)) - 16'd3;
      end else begin
         r.freq_100khz = 16'($urandom_range(65535));
      end
      if ($urandom_range(99) < 25) begin
         r.filter_width = 16'($urandom_range(129));
      end else begin
         r.filter_width = 16'($urandom_range(65535));
      end
      return r;
   endfunction

   task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (RandomPerPhase) send_request(random_request());
   endtask

   initial begin
      stpw_pkg::req_type r;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 22; i++) begin
         r.freq_100khz = DIRECTED_FREQS[i];
         r.filter_width = WIDTH_PICKS[i % 12];
         send_request(r);
      end
      run_random_phase(9, 53);
      run_random_phase(53, 9);
      run_random_phase(0, 0);
      req_valid <= 1'b0;
      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### satellite_tuner_pll_word_core.f
src/stpw_pkg.sv
src/stpw_band.sv
src/stpw_calc.sv
src/satellite_tuner_pll_word_core.sv
test/tb.sv
